// ===== hw/rtl/ffec_pkg.sv =====
package ffec_pkg;

  // Controller modes, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_HOME_UP   = 4'b0010,
    MODE_HOME_DOWN = 4'b0100,
    MODE_TRIP      = 4'b1000
  } mode_t;

  localparam int PORT_W      = 16;
  localparam int FLOOR_W     = 3;
  localparam int GROUP_LINES = 4;    // lines per port group
  localparam int OUT_W       = 16;   // 9 used bits padded to whole bytes

  // port bit positions (active low)
  localparam int SENSOR_LSB  = 0;
  localparam int DOOR_BIT    = 5;
  localparam int LOAD_BIT    = 6;
  localparam int LANDING_LSB = 8;
  localparam int CABIN_LSB   = 12;

  typedef struct packed {
    logic               bell_pulse;
    logic               motor_dir_up;
    logic               motor_on;
    logic               cabin_light;
    logic               arrow_down;
    logic               arrow_up;
    logic [FLOOR_W-1:0] display_value;
  } result_t;

endpackage

// ===== hw/rtl/four_floor_elevator_controller.sv =====
// Elevator controller for up to four floors, one port poll sample per beat.
// Input stream (s_*): each beat carries one raw active-low sample of the
// 16-bit port: floor sensors, door, load and the landing and cabin buttons.
// Output stream (m_*): one result beat per input beat, in order: display
// value, arrows, cabin light, motor enable and direction, bell pulse.
// Pipeline: a sample is captured in an input register at the accepting edge,
// then decoded and applied to the mode state when the result register is
// free, at the edge that registers the result beat and raises m_tvalid.
// Throughput: one beat per cycle unless m_tready stalls; the state update is
// a single pass of three priority encoders and a mode decision between the
// two registers. Reset (rst, synchronous): idle mode, target and latches
// cleared, both stages empty. A stalled m_tready holds the result beat; the
// input stage keeps accepting until it is also full, then s_tready drops.
// FLOOR_COUNT above four is treated as four (the port has four lines per
// group).
module four_floor_elevator_controller
  import ffec_pkg::*;
#(
  parameter int FLOOR_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PORT_W-1:0] s_tdata,   // [15:0] port_in
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // [2:0] display_value, [3] arrow_up,
                                       // [4] arrow_down, [5] cabin_light,
                                       // [6] motor_on, [7] motor_dir_up,
                                       // [8] bell_pulse, [15:9] zero
);

  localparam int FLOORS_USED = (FLOOR_COUNT > GROUP_LINES) ? GROUP_LINES :
                               (FLOOR_COUNT < 1) ? 1 : FLOOR_COUNT;
  localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(FLOORS_USED);
  localparam logic [FLOOR_W-1:0] FIRST_FLOOR = FLOOR_W'(1);

  // lowest active (low) line wins, 0 = none
  function automatic logic [FLOOR_W-1:0] encode(input logic [GROUP_LINES-1:0] grp);
    logic [FLOOR_W-1:0] f;
    f = '0;
    for (int i = FLOORS_USED - 1; i >= 0; i--) begin
      if (!grp[i]) f = FLOOR_W'(i + 1);
    end
    return f;
  endfunction

  // input stage
  logic              in_valid;
  logic [PORT_W-1:0] in_data;

  // state
  mode_t              mode, mode_next;
  logic [FLOOR_W-1:0] target_floor, target_floor_next;
  logic               trip_from_cabin, trip_from_cabin_next;
  logic               going_up, going_up_next;
  logic [FLOOR_W-1:0] display_latch, display_latch_next;
  logic               light_latch, light_latch_next;

  result_t            res, res_next;
  logic               out_valid;

  logic out_free, advance;
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  logic [FLOOR_W-1:0] pos, landing, cabin;
  logic               door_closed, empty;
  logic               bell;

  always_comb begin
    pos     = (in_data == '0) ? '0 :
              encode(in_data[SENSOR_LSB +: GROUP_LINES]);
    landing = encode(in_data[LANDING_LSB +: GROUP_LINES]);
    cabin   = encode(in_data[CABIN_LSB +: GROUP_LINES]);
    door_closed = in_data[DOOR_BIT];
    empty       = in_data[LOAD_BIT];

    mode_next            = mode;
    target_floor_next    = target_floor;
    trip_from_cabin_next = trip_from_cabin;
    going_up_next        = going_up;
    display_latch_next   = display_latch;
    light_latch_next     = light_latch;
    bell                 = 1'b0;

    unique case (mode)
      MODE_IDLE: begin
        display_latch_next = pos;
        light_latch_next   = !door_closed || !empty;
        if (pos == '0) begin
          mode_next = MODE_HOME_UP;
        end else if (door_closed && empty && landing != '0) begin
          if (landing != pos) begin
            target_floor_next    = landing;
            trip_from_cabin_next = 1'b0;
            going_up_next        = landing > pos;
            mode_next            = MODE_TRIP;
          end
        end else if (door_closed && !empty && cabin != '0) begin
          if (cabin != pos) begin
            target_floor_next    = cabin;
            trip_from_cabin_next = 1'b1;
            going_up_next        = cabin > pos;
            mode_next            = MODE_TRIP;
          end else begin
            bell = 1'b1;   // already at the requested floor
          end
        end
      end
      MODE_HOME_UP: begin
        if (pos == TOP_FLOOR) mode_next = MODE_HOME_DOWN;
      end
      MODE_HOME_DOWN: begin
        if (pos == FIRST_FLOOR) mode_next = MODE_IDLE;
      end
      MODE_TRIP: begin
        if (pos == target_floor) begin
          if (trip_from_cabin) begin
            bell = 1'b1;
            if (going_up) display_latch_next = target_floor;
          end
          mode_next = MODE_IDLE;
        end
      end
      default: mode_next = MODE_IDLE;
    endcase

    res_next.display_value = display_latch_next;
    res_next.cabin_light   = light_latch_next;
    res_next.bell_pulse    = bell;
    res_next.motor_on      = 1'b0;
    res_next.motor_dir_up  = 1'b1;
    res_next.arrow_up      = 1'b0;
    res_next.arrow_down    = 1'b0;
    unique case (mode_next)
      MODE_HOME_UP: begin
        res_next.motor_on = 1'b1;
      end
      MODE_HOME_DOWN: begin
        res_next.motor_on     = 1'b1;
        res_next.motor_dir_up = 1'b0;
      end
      MODE_TRIP: begin
        res_next.motor_on     = 1'b1;
        res_next.motor_dir_up = going_up_next;
        res_next.arrow_up     = going_up_next;
        res_next.arrow_down   = !going_up_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      mode            <= MODE_IDLE;
      target_floor    <= '0;
      trip_from_cabin <= 1'b0;
      going_up        <= 1'b0;
      display_latch   <= '0;
      light_latch     <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (out_free) out_valid <= in_valid;
      if (advance) begin
        mode            <= mode_next;
        target_floor    <= target_floor_next;
        trip_from_cabin <= trip_from_cabin_next;
        going_up        <= going_up_next;
        display_latch   <= display_latch_next;
        light_latch     <= light_latch_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_data <= s_tdata;
    if (advance) res <= res_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_W - $bits(result_t))'(0), res};

endmodule

// ===== dv/elevator_checker.sv =====
module elevator_checker
  import ffec_pkg::*;
#(
  parameter int FLOOR_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [PORT_W-1:0] s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [OUT_W-1:0]  m_tdata,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // port has only four lines per group
  localparam int TOP_FLOOR = (FLOOR_COUNT > GROUP_LINES) ? GROUP_LINES :
                             (FLOOR_COUNT < 1) ? 1 : FLOOR_COUNT;

  mode_t               cab_mode;
  logic [FLOOR_W-1:0]  dest_floor;
  logic                dest_by_cabin;
  logic                heading_up;
  logic [FLOOR_W-1:0]  shown_floor;
  logic                lamp;

  result_t expected_results[$];
  int      err_cnt;
  int      beat_idx;

  // lowest active-low line of a group, 0 when none
  function automatic logic [FLOOR_W-1:0] lowest_low(input logic [PORT_W-1:0] p,
                                                    input int lsb);
    for (int i = 0; i < TOP_FLOOR; i++) begin
      if (!p[lsb + i]) return FLOOR_W'(i + 1);
    end
    return '0;
  endfunction

  task automatic predict_outputs(input logic [PORT_W-1:0] p, output result_t r);
    logic [FLOOR_W-1:0] pos;
    logic [FLOOR_W-1:0] landing;
    logic [FLOOR_W-1:0] cabin;
    logic               door_closed;
    logic               empty;
    logic               bell;
    pos = (p == '0) ? '0 : lowest_low(p, SENSOR_LSB);
    landing = lowest_low(p, LANDING_LSB);
    cabin = lowest_low(p, CABIN_LSB);
    door_closed = p[DOOR_BIT];
    empty = p[LOAD_BIT];
    bell = 1'b0;
    case (cab_mode)
      MODE_IDLE: begin
        shown_floor = pos;
        lamp = !door_closed || !empty;
        if (pos == 0) begin
          cab_mode = MODE_HOME_UP;
        end else if (door_closed && empty && landing != 0) begin
          if (landing != pos) begin
            dest_floor = landing;
            dest_by_cabin = 1'b0;
            heading_up = landing > pos;
            cab_mode = MODE_TRIP;
          end
        end else if (door_closed && !empty && cabin != 0) begin
          if (cabin != pos) begin
            dest_floor = cabin;
            dest_by_cabin = 1'b1;
            heading_up = cabin > pos;
            cab_mode = MODE_TRIP;
          end else begin
            bell = 1'b1;
          end
        end
      end
      MODE_HOME_UP: begin
        if (pos == TOP_FLOOR) cab_mode = MODE_HOME_DOWN;
      end
      MODE_HOME_DOWN: begin
        if (pos == 1) cab_mode = MODE_IDLE;
      end
      default: begin
        if (pos == dest_floor) begin
          if (dest_by_cabin) begin
            bell = 1'b1;
            // only an upward cabin trip updates the display on arrival
            if (heading_up) shown_floor = dest_floor;
          end
          cab_mode = MODE_IDLE;
        end
      end
    endcase
    r = '0;
    r.display_value = shown_floor;
    r.cabin_light = lamp;
    r.bell_pulse = bell;
    r.motor_dir_up = 1'b1;
    case (cab_mode)
      MODE_HOME_UP: r.motor_on = 1'b1;
      MODE_HOME_DOWN: begin
        r.motor_on = 1'b1;
        r.motor_dir_up = 1'b0;
      end
      MODE_TRIP: begin
        r.motor_on = 1'b1;
        r.motor_dir_up = heading_up;
        r.arrow_up = heading_up;
        r.arrow_down = !heading_up;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string field, input int exp_v, input int got_v);
    $display("mismatch on beat %0d, %s: expected %0d, got %0d", beat_idx, field,
             exp_v, got_v);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      cab_mode = MODE_IDLE;
      dest_floor = '0;
      dest_by_cabin = 1'b0;
      heading_up = 1'b0;
      shown_floor = '0;
      lamp = 1'b0;
      expected_results.delete();
      err_cnt = 0;
      beat_idx = 0;
    end else begin
      // check the output first so an early result cannot meet its own prediction
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (expected_results.size() == 0) begin
          $display("unexpected result beat %0d: 0x%h", beat_idx, m_tdata);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (got.display_value != want.display_value)
            report_mismatch("display_value", int'(want.display_value),
                            int'(got.display_value));
          if (got.arrow_up != want.arrow_up)
            report_mismatch("arrow_up", int'(want.arrow_up), int'(got.arrow_up));
          if (got.arrow_down != want.arrow_down)
            report_mismatch("arrow_down", int'(want.arrow_down), int'(got.arrow_down));
          if (got.cabin_light != want.cabin_light)
            report_mismatch("cabin_light", int'(want.cabin_light),
                            int'(got.cabin_light));
          if (got.motor_on != want.motor_on)
            report_mismatch("motor_on", int'(want.motor_on), int'(got.motor_on));
          if (got.motor_dir_up != want.motor_dir_up)
            report_mismatch("motor_dir_up", int'(want.motor_dir_up),
                            int'(got.motor_dir_up));
          if (got.bell_pulse != want.bell_pulse)
            report_mismatch("bell_pulse", int'(want.bell_pulse), int'(got.bell_pulse));
        end
        beat_idx++;
      end
      if (s_tvalid && s_tready) begin
        predict_outputs(s_tdata, want);
        expected_results.push_back(want);
      end
    end
    errors <= err_cnt;
    pending <= expected_results.size();
  end

endmodule

// ===== dv/tb_four_floor_elevator_controller.sv =====
module tb_four_floor_elevator_controller;
  import ffec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FLOORS = 4;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [PORT_W-1:0] s_tdata = '1;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  int                errors;
  int                pending;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int walk_floor = 1;
  int quiet_cycles = 0;

  four_floor_elevator_controller #(.FLOOR_COUNT(FLOORS)) DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  elevator_checker #(.FLOOR_COUNT(FLOORS)) u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .errors, .pending
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // active-low port word; 0 for floor/landing/cabin means no line pulled
  function automatic logic [PORT_W-1:0] port_word(input int floor, input bit door_open,
                                                  input bit occupied, input int landing,
                                                  input int cabin);
    logic [PORT_W-1:0] p;
    p = '1;
    if (floor != 0) p[SENSOR_LSB + floor - 1] = 1'b0;
    if (door_open) p[DOOR_BIT] = 1'b0;
    if (occupied) p[LOAD_BIT] = 1'b0;
    if (landing != 0) p[LANDING_LSB + landing - 1] = 1'b0;
    if (cabin != 0) p[CABIN_LSB + cabin - 1] = 1'b0;
    return p;
  endfunction

  // mostly a cabin wandering floor to floor with plausible buttons, some raw noise
  function automatic logic [PORT_W-1:0] next_sample();
    logic [PORT_W-1:0] p;
    int                move;
    if ($urandom_range(99) < 75) begin
      move = $urandom_range(9);
      if (move < 2 && walk_floor > 1) walk_floor--;
      else if (move > 6 && walk_floor < FLOORS) walk_floor++;
      p = port_word(($urandom_range(99) < 80) ? walk_floor : 0,
                    $urandom_range(99) < 15, 1'($urandom_range(1)),
                    ($urandom_range(99) < 40) ? $urandom_range(1, FLOORS) : 0,
                    ($urandom_range(99) < 40) ? $urandom_range(1, FLOORS) : 0);
      p[4] = 1'($urandom_range(1));
      p[7] = 1'($urandom_range(1));
    end else begin
      p = PORT_W'($urandom);
    end
    return p;
  endfunction

  task automatic send_sample(input logic [PORT_W-1:0] p);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    int idle_cfg[4];
    int stall_cfg[4];
    idle_cfg = '{0, 64, 0, 10};
    stall_cfg = '{0, 0, 64, 10};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // homing from between floors, up to the top and back to floor one
    send_sample(16'hFFFF);
    send_sample(port_word(2, 0, 0, 0, 0));
    send_sample(port_word(4, 0, 0, 0, 0));
    send_sample(port_word(3, 0, 0, 0, 0));
    send_sample(port_word(1, 0, 0, 0, 0));
    // landing call trip up, empty cabin
    send_sample(port_word(1, 0, 0, 3, 0));
    send_sample(port_word(2, 0, 0, 0, 0));
    send_sample(port_word(3, 0, 0, 0, 0));
    // calls to the current floor
    send_sample(port_word(3, 0, 0, 3, 0));
    send_sample(port_word(3, 0, 1, 0, 3));
    // cabin trip up: bell and display update on arrival
    send_sample(port_word(3, 0, 1, 0, 4));
    send_sample(port_word(4, 0, 1, 0, 0));
    // both buttons, occupied: cabin trip down
    send_sample(port_word(4, 0, 1, 2, 1));
    send_sample(port_word(2, 0, 1, 0, 0));
    send_sample(port_word(1, 0, 1, 0, 0));
    // door open blocks everything and lights the cabin
    send_sample(port_word(1, 1, 1, 3, 2));
    // both buttons, empty: landing call wins
    send_sample(port_word(1, 0, 0, 2, 3));
    send_sample(port_word(2, 0, 0, 0, 0));
    // all-zero port reads as between floors
    send_sample(16'h0000);
    send_sample(16'h0007);
    send_sample(16'h0000);
    send_sample(16'hFFFE);
    send_sample(16'h0000);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_cfg[ph];
      stall_pct = stall_cfg[ph];
      // fill the pipeline against a stalled result side
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_sample(next_sample());
    end
    s_tvalid <= 1'b0;
    // pending is registered, so it lags the last accepted beat
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ffec_pkg.sv
hw/rtl/four_floor_elevator_controller.sv
dv/elevator_checker.sv
dv/tb_four_floor_elevator_controller.sv
